FILE: design/segment_display_led_frame_builder_macros.svh
// assertion macros of the frame builder checker
`ifndef SEGMENT_DISPLAY_LED_FRAME_BUILDER_MACROS_SVH
`define SEGMENT_DISPLAY_LED_FRAME_BUILDER_MACROS_SVH

// property checked outside reset
`define SDLFB_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("frame builder assertion failed");

// property checked on every edge, reset included
`define SDLFB_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("frame builder assertion failed");

`endif

FILE: design/sdlfb_pkg.sv
// shared constants and types of the segment display frame builder
`timescale 1ns / 1ps

package sdlfb_pkg;

  localparam int DIGITS   = 3;
  localparam int SEGMENTS = 7;

  localparam int MASK_W  = 7;
  localparam int LEVEL_W = 8;
  localparam int DIGIT_W = 2;
  localparam int COUNT_W = 8;
  localparam int SEG_W   = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;

  localparam logic [LEVEL_W-1:0] COLOR_RESET   = 8'hFF;
  localparam logic [COUNT_W-1:0] STARTUP_RESET = 8'd10;
  localparam logic [COUNT_W-1:0] COUNT_MAX     = 8'hFF;

  // position within one segment's three-byte group
  typedef enum logic [1:0] {
    COLOR_GREEN,
    COLOR_RED,
    COLOR_BLUE
  } color_t;

  // controller to datapath
  typedef struct packed {
    logic               capture;
    logic               emit;
    logic [DIGIT_W-1:0] digit;
    logic [SEG_W-1:0]   seg_bit;
    color_t             color;
    logic               last_digit;
    logic               last_item;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [DIGITS-1:0] send_now;
    logic              out_room;
  } dp_stat_t;

endpackage

FILE: design/sdlfb_ctrl.sv
// controller: walks digits, segments and colors of one transaction
`timescale 1ns / 1ps

module sdlfb_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  sdlfb_pkg::dp_stat_t stat,
  output sdlfb_pkg::dp_cmd_t  cmd
);

  import sdlfb_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  state_t             state;
  logic [DIGITS-1:0]  pending;
  logic [SEG_W-1:0]   seg_bit;
  color_t             color;
  logic [DIGIT_W-1:0] cur_digit;
  logic               accept;
  logic               last_digit;
  logic               last_item;

  // lowest digit still to send
  always_comb begin
    cur_digit = '0;
    for (int i = DIGITS - 1; i >= 0; i--) begin
      if (pending[i]) begin
        cur_digit = DIGIT_W'(i);
      end
    end
  end

  assign accept     = in_valid && !in_stall;
  assign last_digit = (seg_bit == '0) && (color == COLOR_BLUE);
  assign last_item  = last_digit &&
                      ((pending & (pending - DIGITS'(1))) == '0);

  // command to datapath
  always_comb begin
    cmd.capture    = accept;
    cmd.emit       = (state == ST_RUN) && stat.out_room;
    cmd.digit      = cur_digit;
    cmd.seg_bit    = seg_bit;
    cmd.color      = color;
    cmd.last_digit = last_digit;
    cmd.last_item  = last_item;
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      in_stall <= 1'b0;
      pending  <= '0;
      seg_bit  <= SEG_W'(SEGMENTS - 1);
      color    <= COLOR_GREEN;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            pending <= stat.send_now;
            seg_bit <= SEG_W'(SEGMENTS - 1);
            color   <= COLOR_GREEN;
            if (stat.send_now != '0) begin
              state    <= ST_RUN;
              in_stall <= 1'b1;
            end
          end
        end
        ST_RUN: begin
          if (cmd.emit) begin
            case (color)
              COLOR_GREEN: color <= COLOR_RED;
              COLOR_RED:   color <= COLOR_BLUE;
              default:     color <= COLOR_GREEN;
            endcase
            if (color == COLOR_BLUE) begin
              if (seg_bit != '0) begin
                seg_bit <= seg_bit - SEG_W'(1);
              end else begin
                seg_bit <= SEG_W'(SEGMENTS - 1);
                pending <= pending & ~(DIGITS'(1) << cur_digit);
              end
            end
            if (last_item) begin
              state    <= ST_IDLE;
              in_stall <= 1'b0;
            end
          end
        end
        default: begin
          state    <= ST_IDLE;
          in_stall <= 1'b0;
        end
      endcase
    end
  end

endmodule

FILE: design/sdlfb_dp.sv
// datapath: stored copies, start-up counter, byte select and output register
`timescale 1ns / 1ps

module sdlfb_dp (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [sdlfb_pkg::COUNT_W-1:0]   cfg_wdata,
  input  logic [sdlfb_pkg::MASK_W-1:0]    digit0_segments,
  input  logic [sdlfb_pkg::MASK_W-1:0]    digit1_segments,
  input  logic [sdlfb_pkg::MASK_W-1:0]    digit2_segments,
  input  logic [sdlfb_pkg::LEVEL_W-1:0]   green_level,
  input  logic [sdlfb_pkg::LEVEL_W-1:0]   red_level,
  input  logic [sdlfb_pkg::LEVEL_W-1:0]   blue_level,
  input  sdlfb_pkg::dp_cmd_t              cmd,
  output sdlfb_pkg::dp_stat_t             stat,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [sdlfb_pkg::DIGIT_W-1:0]   digit_index,
  output logic [sdlfb_pkg::LEVEL_W-1:0]   color_byte,
  output logic                            last_of_digit,
  output logic                            last_of_item
);

  import sdlfb_pkg::*;

  logic [COUNT_W-1:0] startup_ticks;
  logic [COUNT_W-1:0] startup_count;
  logic [MASK_W-1:0]  prev_segments [DIGITS];
  logic [LEVEL_W-1:0] prev_green;
  logic [LEVEL_W-1:0] prev_red;
  logic [LEVEL_W-1:0] prev_blue;

  logic [MASK_W-1:0]  mask_q [DIGITS];
  logic [LEVEL_W-1:0] green_q;
  logic [LEVEL_W-1:0] red_q;
  logic [LEVEL_W-1:0] blue_q;
  logic               dark_q;

  logic [MASK_W-1:0]  mask_in [3];
  logic               dark;
  logic               color_changed;
  logic [MASK_W-1:0]  cur_mask;
  logic               lit;
  logic [LEVEL_W-1:0] byte_next;

  assign mask_in[0] = digit0_segments;
  assign mask_in[1] = digit1_segments;
  assign mask_in[2] = digit2_segments;

  // which digits this transaction sends
  assign dark          = (startup_count <= startup_ticks);
  assign color_changed = (green_level != prev_green) || (red_level != prev_red) ||
                         (blue_level != prev_blue);

  always_comb begin
    for (int d = 0; d < DIGITS; d++) begin
      stat.send_now[d] = dark || color_changed || (mask_in[d] != prev_segments[d]);
    end
    stat.out_room = !out_valid || !out_stall;
  end

  // start-up register
  always_ff @(posedge clk) begin
    if (rst) begin
      startup_ticks <= STARTUP_RESET;
    end else if (cfg_we) begin
      startup_ticks <= cfg_wdata;
    end
  end

  // stored copies and start-up counter
  always_ff @(posedge clk) begin
    if (rst) begin
      startup_count <= '0;
      prev_green    <= COLOR_RESET;
      prev_red      <= COLOR_RESET;
      prev_blue     <= COLOR_RESET;
      for (int d = 0; d < DIGITS; d++) begin
        prev_segments[d] <= '0;
      end
    end else if (cmd.capture) begin
      if (dark) begin
        if (startup_count != COUNT_MAX) begin
          startup_count <= startup_count + COUNT_W'(1);
        end
      end else begin
        prev_green <= green_level;
        prev_red   <= red_level;
        prev_blue  <= blue_level;
        for (int d = 0; d < DIGITS; d++) begin
          prev_segments[d] <= mask_in[d];
        end
      end
    end
  end

  // working copy of the accepted transaction
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      dark_q  <= dark;
      green_q <= green_level;
      red_q   <= red_level;
      blue_q  <= blue_level;
      for (int d = 0; d < DIGITS; d++) begin
        mask_q[d] <= mask_in[d];
      end
    end
  end

  // byte select
  assign cur_mask = mask_q[cmd.digit];
  assign lit      = !dark_q && cur_mask[cmd.seg_bit];

  always_comb begin
    case (cmd.color)
      COLOR_GREEN: byte_next = green_q;
      COLOR_RED:   byte_next = red_q;
      COLOR_BLUE:  byte_next = blue_q;
      default:     byte_next = '0;
    endcase
    if (!lit) begin
      byte_next = '0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      digit_index   <= cmd.digit;
      color_byte    <= byte_next;
      last_of_digit <= cmd.last_digit;
      last_of_item  <= cmd.last_item;
    end
  end

endmodule

FILE: design/segment_display_led_frame_builder.sv
// top level of the segment display LED frame builder
//
//  channel | handshake           | payload
//  --------+---------------------+----------------------------------------------
//  input   | in_valid / in_stall | digit0..2_segments, green/red/blue_level
//  output  | out_valid/out_stall | digit_index, color_byte, last_of_digit/item
//  config  | cfg_we              | cfg_wdata (startup_ticks)
//
// the byte sequencer emits 21 bytes for each digit sent, seven segments of three
// colors each, one byte per cycle while the output is not stalled.
// rst is synchronous: stored copies go to mask 0 and colors 0xFF, start-up
// count to 0, startup_ticks to 10. an output stall freezes the sequencer;
// in_stall stays high until the last byte of the transaction is registered.
`timescale 1ns / 1ps

module segment_display_led_frame_builder (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [sdlfb_pkg::COUNT_W-1:0]   cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [sdlfb_pkg::MASK_W-1:0]    digit0_segments,
  input  logic [sdlfb_pkg::MASK_W-1:0]    digit1_segments,
  input  logic [sdlfb_pkg::MASK_W-1:0]    digit2_segments,
  input  logic [sdlfb_pkg::LEVEL_W-1:0]   green_level,
  input  logic [sdlfb_pkg::LEVEL_W-1:0]   red_level,
  input  logic [sdlfb_pkg::LEVEL_W-1:0]   blue_level,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [sdlfb_pkg::DIGIT_W-1:0]   digit_index,
  output logic [sdlfb_pkg::LEVEL_W-1:0]   color_byte,
  output logic                            last_of_digit,
  output logic                            last_of_item
);

  import sdlfb_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencer
  sdlfb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath
  sdlfb_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .digit0_segments (digit0_segments),
    .digit1_segments (digit1_segments),
    .digit2_segments (digit2_segments),
    .green_level     (green_level),
    .red_level       (red_level),
    .blue_level      (blue_level),
    .cmd             (cmd),
    .stat            (stat),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .digit_index     (digit_index),
    .color_byte      (color_byte),
    .last_of_digit   (last_of_digit),
    .last_of_item    (last_of_item)
  );

endmodule

FILE: design/sdlfb_checker.sv
// port-level checks of the frame builder, bound to the top level
`timescale 1ns / 1ps
`include "segment_display_led_frame_builder_macros.svh"

module sdlfb_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_stall,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic [sdlfb_pkg::LEVEL_W-1:0]   color_byte,
  input logic                            last_of_digit,
  input logic                            last_of_item
);

  // nothing leaves the block in the cycle after reset
  `SDLFB_ASSERT_ALWAYS(a_reset_clears_out, clk, rst |=> !out_valid)

  // a stalled byte stays put
  `SDLFB_ASSERT(a_out_hold, clk, rst, out_valid && out_stall |=> out_valid && $stable(color_byte))

  // the end of a transaction always closes a digit run
  `SDLFB_ASSERT(a_item_ends_digit, clk, rst, out_valid && last_of_item |-> last_of_digit)

  // input is held off while a transaction's run is not finished
  `SDLFB_ASSERT(a_busy_while_run, clk, rst, out_valid && !last_of_item |-> in_stall)

endmodule

bind segment_display_led_frame_builder sdlfb_checker u_sdlfb_checker (.*);
